// File: sv/cost_benefit_victim_select_unit_defines.svh
// Assertion macros used by the victim select unit datapath (cbvs_dp).
// No dependencies; the using module must have i_clk and i_rst_n in scope.
`ifndef COST_BENEFIT_VICTIM_SELECT_UNIT_DEFINES_SVH
`define COST_BENEFIT_VICTIM_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define CBVS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define CBVS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/cbvs_pkg.sv
// Shared types and constants for the cost-benefit victim select unit.
// No dependencies.
package cbvs_pkg;

    localparam int SEG_W        = 10;
    localparam int FREE_W       = 16;
    localparam int AGE_IN_W     = 32;
    localparam int PICK_W       = 5;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int MAX_SEGMENTS = 1024;
    localparam int DEF_MAX_PICK = 16;
    localparam int DEF_AGE_BITS = 32;

    localparam logic [FREE_W-1:0] USABLE_RESET = 16'd63;
    localparam logic [PICK_W-1:0] PICK_RESET   = 5'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USABLE = 1'b0,
        CFG_PICK   = 1'b1
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic load_rec;
        logic inc_idx;
        logic insert;
        logic prep_emit;
        logic emit_load;
        logic clear_fill;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fill_zero;
        logic idx_at_end;
        logic ranks_first;
        logic rec_last;
        logic emit_end;
        logic out_free;
    } t_sts;

endpackage

// File: sv/cbvs_rec_if.sv
// Record and victim channels of the victim select unit.
// Depends on cbvs_pkg.
interface cbvs_rec_if import cbvs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEG_W-1:0]    segment_number;
    logic [FREE_W-1:0]   free_count;
    logic [AGE_IN_W-1:0] newest_age;
    logic                is_last;

    modport source (output valid, segment_number, free_count, newest_age, is_last,
                    input ready);
    modport sink   (input valid, segment_number, free_count, newest_age, is_last,
                    output ready);
endinterface

interface cbvs_vic_if import cbvs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] victim_segment;
    logic             last_victim;

    modport source (output valid, victim_segment, last_victim, input ready);
    modport sink   (input valid, victim_segment, last_victim, output ready);
endinterface

// File: sv/cbvs_ctrl.sv
// Sequencer for the victim select unit: scan, insert and emit phases.
// Depends on cbvs_pkg.
module cbvs_ctrl import cbvs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_M1   = 6'b000010,
        ST_M2   = 6'b000100,
        ST_CMP  = 6'b001000,
        ST_INS  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_prep, n_prep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prep  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prep  <= n_prep;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_prep  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_rec = 1'b1;
                    n_state = i_sts.fill_zero ? ST_INS : ST_M1;
                end
            end
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_CMP;
            ST_CMP: begin
                if (i_sts.ranks_first) begin
                    n_state = ST_INS;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state = i_sts.idx_at_end ? ST_INS : ST_M1;
                end
            end
            ST_INS: begin
                o_cmd.insert = 1'b1;
                if (i_sts.rec_last) begin
                    n_state = ST_EMIT;
                    n_prep  = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // first cycle sets up count and index from the updated list
                if (r_prep) begin
                    o_cmd.prep_emit = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.emit_end) begin
                        o_cmd.clear_fill = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: sv/cbvs_dp.sv
// Datapath of the victim select unit: config registers, sorted list,
// cross-multiply comparator and output register. Depends on cbvs_pkg.
module cbvs_dp import cbvs_pkg::*; #(
    parameter int MAX_PICK = DEF_MAX_PICK,
    parameter int AGE_BITS = DEF_AGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [SEG_W-1:0]     i_seg,
    input  logic [FREE_W-1:0]    i_free,
    input  logic [AGE_IN_W-1:0]  i_age,
    input  logic                 i_last,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [SEG_W-1:0]     o_out_seg,
    output logic                 o_out_last,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);
    `include "cost_benefit_victim_select_unit_defines.svh"

    localparam int IW   = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int CW   = $clog2(MAX_PICK + 1);
    localparam int PW   = FREE_W + AGE_BITS;
    localparam int LO_W = PW / 2;
    localparam int HI_W = PW - LO_W;
    localparam int DW   = FREE_W + 1;
    localparam int TW   = PW + DW;
    localparam logic [63:0] AGE_MAX = (64'd1 << AGE_BITS) - 64'd1;

    // Configuration
    logic [FREE_W-1:0] r_usable;
    logic [PICK_W-1:0] r_pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= USABLE_RESET;
            r_pick   <= PICK_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_USABLE: r_usable <= i_cfg_data;
                CFG_PICK:   r_pick   <= i_cfg_data[PICK_W-1:0];
                default:    ;
            endcase
        end
    end

    logic [FREE_W-1:0] u;
    logic [DW-1:0]     u2;
    assign u  = (r_usable == '0) ? FREE_W'(1) : r_usable;
    assign u2 = {u, 1'b0};

    // Current record, saturated on load
    logic [SEG_W-1:0]    r_rseg;
    logic [FREE_W-1:0]   r_rfree;
    logic [AGE_BITS-1:0] r_rage;
    logic                r_rlast;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rec) begin
            r_rseg  <= (32'(i_seg) >= MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS - 1) : i_seg;
            r_rfree <= (i_free > u) ? u : i_free;
            r_rage  <= (64'(i_age) > AGE_MAX) ? AGE_BITS'(AGE_MAX) : AGE_BITS'(i_age);
            r_rlast <= i_last;
        end
    end

    // Sorted list storage
    logic [SEG_W-1:0]    r_eseg  [MAX_PICK];
    logic [FREE_W-1:0]   r_efree [MAX_PICK];
    logic [AGE_BITS-1:0] r_eage  [MAX_PICK];
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_cnt;
    logic [IW-1:0]       e;

    assign e = r_idx[IW-1:0];

    // Comparator stage 1: free*age and the opposite denominators
    logic [FREE_W-1:0] fa, fb;
    logic [PW-1:0]     r_pa, r_pb;
    logic [DW-1:0]     r_da, r_db;

    assign fa = (r_rfree > u) ? u : r_rfree;
    assign fb = (r_efree[e] > u) ? u : r_efree[e];

    always_ff @(posedge i_clk) begin
        r_pa <= PW'(fa * r_rage);
        r_pb <= PW'(fb * r_eage[e]);
        r_da <= u2 - DW'(fb);
        r_db <= u2 - DW'(fa);
    end

    // Comparator stage 2: split partial products by the denominator
    logic [LO_W+DW-1:0] r_la_lo, r_lb_lo;
    logic [HI_W+DW-1:0] r_la_hi, r_lb_hi;

    always_ff @(posedge i_clk) begin
        r_la_lo <= (LO_W+DW)'(r_pa[LO_W-1:0] * r_da);
        r_la_hi <= (HI_W+DW)'(r_pa[PW-1:LO_W] * r_da);
        r_lb_lo <= (LO_W+DW)'(r_pb[LO_W-1:0] * r_db);
        r_lb_hi <= (HI_W+DW)'(r_pb[PW-1:LO_W] * r_db);
    end

    // Comparator stage 3: recombine and rank, lower segment wins a tie
    logic [TW-1:0] left_v, right_v;
    assign left_v  = (TW'(r_la_hi) << LO_W) + TW'(r_la_lo);
    assign right_v = (TW'(r_lb_hi) << LO_W) + TW'(r_lb_lo);

    // Effective pick count clamped to 1..MAX_PICK
    logic [CW-1:0] k;
    always_comb begin
        if (32'(r_pick) >= MAX_PICK)  k = CW'(MAX_PICK);
        else if (r_pick == '0)        k = CW'(1);
        else                          k = CW'(r_pick);
    end

    // List update: shift down below the insert point
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && (32'(r_idx) < MAX_PICK)) begin
            for (int i = 0; i < MAX_PICK; i++) begin
                if (CW'(i) == r_idx) begin
                    r_eseg[i]  <= r_rseg;
                    r_efree[i] <= r_rfree;
                    r_eage[i]  <= r_rage;
                end else if (i > 0 && CW'(i) > r_idx && CW'(i) <= r_fill) begin
                    r_eseg[i]  <= r_eseg[i-1];
                    r_efree[i] <= r_efree[i-1];
                    r_eage[i]  <= r_eage[i-1];
                end
            end
        end
    end

    // Fill count, scan/emit index and emit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.clear_fill)
                r_fill <= '0;
            else if (i_cmd.insert && (32'(r_idx) < MAX_PICK) && (32'(r_fill) < MAX_PICK))
                r_fill <= r_fill + CW'(1);
            if (i_cmd.load_rec || i_cmd.prep_emit)
                r_idx <= '0;
            else if (i_cmd.inc_idx || i_cmd.emit_load)
                r_idx <= r_idx + CW'(1);
            if (i_cmd.prep_emit)
                r_cnt <= (r_fill < k) ? r_fill : k;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_out_seg  <= r_eseg[e];
            o_out_last <= (r_idx + CW'(1) == r_cnt);
        end
    end

    // Status
    assign o_sts.fill_zero   = (r_fill == '0);
    assign o_sts.idx_at_end  = (r_idx + CW'(1) == r_fill);
    assign o_sts.ranks_first = (left_v > right_v) ||
                               ((left_v == right_v) && (r_rseg < r_eseg[e]));
    assign o_sts.rec_last    = r_rlast;
    assign o_sts.emit_end    = (r_idx + CW'(1) == r_cnt);
    assign o_sts.out_free    = !o_out_valid || i_out_ready;

    `CBVS_ASSERT_IMP(a_fill_bound, 1'b1, 32'(r_fill) <= MAX_PICK, "list fill beyond depth")
    `CBVS_ASSERT_NXT(a_insert_fills, i_cmd.insert, r_fill != '0, "insert left list empty")
    `CBVS_ASSERT_IMP(a_emit_in_list, i_cmd.emit_load, r_idx < r_fill && r_idx < r_cnt, "emit beyond list")

endmodule

// File: sv/cost_benefit_victim_select_unit.sv
// Top level of the cost-benefit victim select unit.
// Depends on cbvs_pkg, cbvs_rec_if, cbvs_vic_if, cbvs_ctrl and cbvs_dp.
//
// Takes one segment record per item and keeps the best MAX_PICK records in a
// sorted list, ranked by free*age/(2*usable-free) through exact cross-multiply
// compares (ties to the lower segment number). A record is compared against
// the kept entries one after another through a three-stage shared multiplier,
// stopping at the first entry it outranks. On a record marked last, the best
// min(pick_count, entries) segment numbers are sent one per cycle while the
// output is not stalled, after a setup step, best first, and the list is
// emptied. Records are accepted only between items; a victim waiting in the
// output register does not block the next record.
module cost_benefit_victim_select_unit import cbvs_pkg::*; #(
    parameter int MAX_PICK = DEF_MAX_PICK,
    parameter int AGE_BITS = DEF_AGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    cbvs_rec_if.sink             i_rec,
    cbvs_vic_if.source           o_vic
);

    t_cmd cmd;
    t_sts sts;

    cbvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rec.valid),
        .o_in_ready (i_rec.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cbvs_dp #(
        .MAX_PICK (MAX_PICK),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_seg       (i_rec.segment_number),
        .i_free      (i_rec.free_count),
        .i_age       (i_rec.newest_age),
        .i_last      (i_rec.is_last),
        .i_out_ready (o_vic.ready),
        .o_out_valid (o_vic.valid),
        .o_out_seg   (o_vic.victim_segment),
        .o_out_last  (o_vic.last_victim),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
